FILE: hw/rtl/dfsle_pkg.sv
// Shared types, constants and codes for the DFS leader election node.
`timescale 1ns / 1ps
`default_nettype none

package dfsle_pkg;

    // rank width of the election logic and child list depth
    localparam int RANK_BITS    = 8;
    localparam int MAX_CHILDREN = 4;

    // port field widths
    localparam int FIELD_W = 8;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 3;
    localparam int INDEX_W = 3;

    // ranks arrive on 8-bit fields, so only the low bits that fit are kept
    localparam int RANK_W     = (RANK_BITS < FIELD_W) ? RANK_BITS : FIELD_W;
    localparam int NUM_SLOTS  = 4;
    localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
    localparam int CHILD_W    = $clog2(MAX_CHILDREN + 1);

    typedef logic [RANK_W-1:0] rank_t;

    typedef enum logic [KIND_W-1:0] {
        EV_START   = 2'd0,
        EV_LEADER  = 2'd1,
        EV_ALREADY = 2'd2,
        EV_PARENT  = 2'd3
    } ev_kind_t;

    typedef enum logic [KIND_W-1:0] {
        MSG_LEADER  = 2'd0,
        MSG_PARENT  = 2'd1,
        MSG_ALREADY = 2'd2,
        MSG_DONE    = 2'd3
    } msg_kind_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_OWN   = 3'd0,
        REG_UP    = 3'd1,
        REG_DOWN  = 3'd2,
        REG_LEFT  = 3'd3,
        REG_RIGHT = 3'd4
    } reg_index_t;

    // election state of the node
    typedef struct packed {
        rank_t                        leader;
        rank_t                        parent;
        logic [NUM_SLOTS-1:0][RANK_W-1:0] slots;  // up, down, left, right
        logic [CHILD_W-1:0]           child_total;
    } node_state_t;

    // one outgoing message as it leaves on the result channel
    typedef struct packed {
        msg_kind_t          msg_kind;
        logic [FIELD_W-1:0] dest_rank;
        logic [FIELD_W-1:0] leader_out;
        logic [COUNT_W-1:0] child_count;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dfs_leader_election_node.sv
// Top level of the DFS spanning-tree leader election node.
// Each result is registered into the result register or, behind a full one, the skid entry.
// Throughput: one event per cycle while s_tready is high (compares and a four-slot priority pick).
// A result register plus skid entry keep s_tready high while a result waits;
//   s_tready drops only when both are full.
// Reset (aresetn, synchronous, active low): own rank 1, no neighbors, no
//   parent, no children, output buffer empty. Any write to a known register reinitializes.
`timescale 1ns / 1ps
`default_nettype none

module dfs_leader_election_node
    import dfsle_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    // configuration write port
    input  wire logic               cfg_wr_en,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [FIELD_W-1:0] cfg_wdata,

    // event input
    input  wire logic               s_tvalid,
    output      logic               s_tready,
    input  wire logic [15:0]        s_tdata,   // [7:0] src_rank, [15:8] leader_value
    input  wire logic [KIND_W-1:0]  s_tuser,   // [1:0] kind

    // outgoing message
    output      logic               m_tvalid,
    input  wire logic               m_tready,
    output      logic [23:0]        m_tdata,   // [7:0] dest_rank, [15:8] leader_out,
                                               // [18:16] child_count, rest zero
    output      logic [KIND_W-1:0]  m_tuser    // [1:0] msg_kind
);

    // configuration copies
    rank_t                            own_rank_reg;
    logic [NUM_SLOTS-1:0][RANK_W-1:0] nbr_rank_reg;
    logic [NUM_SLOTS-1:0][RANK_W-1:0] nbr_cfg;

    // election state
    node_state_t state_reg;
    node_state_t state_next;

    // output buffer: result register and skid entry
    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    logic    in_xfer;
    logic    out_xfer;
    logic    res_valid;
    result_t res;
    logic    push;
    rank_t   cfg_rank;

    assign s_tready = !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign push     = in_xfer && res_valid;
    assign cfg_rank = cfg_wdata[RANK_W-1:0];

    // neighbor table as it stands after a neighbor register write
    always_comb begin
        nbr_cfg = nbr_rank_reg;
        if (cfg_index inside {REG_UP, REG_DOWN, REG_LEFT, REG_RIGHT}) begin
            nbr_cfg[SLOT_IDX_W'(cfg_index - REG_UP)] = cfg_rank;
        end
    end

    dfsle_core u_core (
        .st           (state_reg),
        .own_rank     (own_rank_reg),
        .nbr_rank     (nbr_rank_reg),
        .kind         (ev_kind_t'(s_tuser)),
        .src_rank     (s_tdata[RANK_W-1:0]),
        .leader_value (s_tdata[FIELD_W+RANK_W-1:FIELD_W]),
        .st_next      (state_next),
        .res_valid    (res_valid),
        .res          (res)
    );

    // configuration and election state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_rank_reg          <= rank_t'(1);
            nbr_rank_reg          <= '0;
            state_reg.leader      <= rank_t'(1);
            state_reg.parent      <= '0;
            state_reg.slots       <= '0;
            state_reg.child_total <= '0;
        end else if (cfg_wr_en) begin
            // every known register reloads the election from scratch
            case (cfg_index)
                REG_OWN: begin
                    own_rank_reg          <= cfg_rank;
                    state_reg.leader      <= cfg_rank;
                    state_reg.parent      <= '0;
                    state_reg.slots       <= nbr_rank_reg;
                    state_reg.child_total <= '0;
                end
                REG_UP, REG_DOWN, REG_LEFT, REG_RIGHT: begin
                    nbr_rank_reg          <= nbr_cfg;
                    state_reg.leader      <= own_rank_reg;
                    state_reg.parent      <= '0;
                    state_reg.slots       <= nbr_cfg;
                    state_reg.child_total <= '0;
                end
                default: ;
            endcase
        end else if (in_xfer) begin
            state_reg <= state_next;
        end
    end

    // output buffer control; a push only happens while the skid is empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_xfer) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_xfer) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        if (push && out_valid_reg && !out_xfer) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.msg_kind;
    assign m_tdata  = {5'd0, out_reg.child_count, out_reg.leader_out, out_reg.dest_rank};

    // skid entry is only ever filled behind a full result register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty result register");

    // a known register write clears parent and children
    a_cfg_reinit: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && (cfg_index == REG_OWN || cfg_index == REG_UP ||
                      cfg_index == REG_DOWN || cfg_index == REG_LEFT ||
                      cfg_index == REG_RIGHT)
        |=> state_reg.parent == '0 && state_reg.child_total == '0)
        else $error("config write did not reinitialize election state");

    a_child_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.child_total <= CHILD_W'(MAX_CHILDREN))
        else $error("child count above limit");

    // election done always goes to the coordinator
    a_done_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == MSG_DONE |-> m_tdata[7:0] == 8'd0)
        else $error("election done not addressed to coordinator");

    // a full buffer drained by a transfer still shows the skid result next
    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && out_xfer |=> m_tvalid && !skid_valid_reg)
        else $error("skid result lost on drain");

endmodule

`default_nettype wire

FILE: hw/rtl/dfsle_core.sv
// Event decode and next-state logic of the election node (combinational).
`timescale 1ns / 1ps
`default_nettype none

module dfsle_core
    import dfsle_pkg::*;
(
    input  node_state_t                      st,
    input  rank_t                            own_rank,
    input  logic [NUM_SLOTS-1:0][RANK_W-1:0] nbr_rank,
    input  ev_kind_t                         kind,
    input  rank_t                            src_rank,
    input  rank_t                            leader_value,
    output node_state_t                      st_next,
    output logic                             res_valid,
    output result_t                          res
);

    node_state_t            mid;
    logic                   do_explore;
    logic                   found;
    logic [SLOT_IDX_W-1:0]  pick;
    msg_kind_t              kind_out;
    rank_t                  dest;

    always_comb begin
        mid        = st;
        do_explore = 1'b0;
        res_valid  = 1'b0;
        kind_out   = MSG_LEADER;
        dest       = '0;
        found      = 1'b0;
        pick       = '0;

        case (kind)
            EV_START: begin
                if (st.parent == '0) begin
                    mid.parent = own_rank;
                    do_explore = (own_rank != '0);
                end
            end
            EV_LEADER: begin
                if (st.leader < leader_value) begin
                    mid.leader      = leader_value;
                    mid.parent      = src_rank;
                    mid.child_total = '0;
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        mid.slots[i] = (nbr_rank[i] == src_rank) ? '0 : nbr_rank[i];
                    end
                    do_explore = 1'b1;
                end else if (st.leader == leader_value) begin
                    res_valid = 1'b1;
                    kind_out  = MSG_ALREADY;
                    dest      = src_rank;
                end
            end
            EV_ALREADY: begin
                do_explore = (st.leader == leader_value);
            end
            EV_PARENT: begin
                if (st.leader == leader_value) begin
                    // child list saturates; ranks themselves never feed a result
                    if (st.child_total < CHILD_W'(MAX_CHILDREN)) begin
                        mid.child_total = st.child_total + CHILD_W'(1);
                    end
                    do_explore = 1'b1;
                end
            end
            default: ;
        endcase

        st_next = mid;

        // first nonzero slot wins: scan from the top so the lowest index sticks
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (mid.slots[i] != '0) begin
                found = 1'b1;
                pick  = SLOT_IDX_W'(i);
            end
        end

        if (do_explore) begin
            res_valid = 1'b1;
            if (found) begin
                kind_out           = MSG_LEADER;
                dest               = mid.slots[pick];
                st_next.slots[pick] = '0;
            end else if (mid.parent != own_rank) begin
                kind_out = MSG_PARENT;
                dest     = mid.parent;
            end else begin
                kind_out = MSG_DONE;
                dest     = '0;
            end
        end

        res.msg_kind    = kind_out;
        res.dest_rank   = FIELD_W'(dest);
        res.leader_out  = FIELD_W'(st_next.leader);
        res.child_count = COUNT_W'(st_next.child_total);
    end

endmodule

`default_nettype wire
